>>> rtl/lsu_pkg.sv
// Shared constants and elaboration-time helpers for the logistic SGD update block.
// Holds fixed-point widths, reset values and the sigmoid table entry function.
// No dependencies.
package lsu_pkg;

  // Default sizing
  localparam int unsigned DEF_SIGMOID_TABLE_DEPTH = 1024;
  localparam int unsigned DEF_FEATURE_WIDTH       = 16;

  // Field widths
  localparam int unsigned P_W    = 17;  // Q0.16 probability, 65536 = 1.0
  localparam int unsigned W_W    = 32;  // Q16.16 weight
  localparam int unsigned RATE_W = 24;  // Q0.32 step size
  localparam int unsigned MUL_W  = 33;  // shared multiplier operand width
  localparam int unsigned STEP_W = 25;  // scaled gradient, Q0.32
  localparam int unsigned DELTA_W = 33; // weight increment before saturation

  localparam logic [RATE_W-1:0] RATE_RESET = 24'd429497;
  localparam int unsigned       P_ONE      = 65536;
  localparam int unsigned       Z_HALF     = 524288;  // 8.0 in Q16.16
  localparam int unsigned       Z_FRAC     = 20;      // log2 of the full z span

  // Unsigned restoring division, used only while building constant tables
  function automatic longint unsigned udiv(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned q;
    longint unsigned rem;
    q   = 0;
    rem = 0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem  = rem - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Sigmoid of a nonnegative Q16.16 argument, Q0.16 result
  function automatic logic [P_W-1:0] sig_pos(input longint unsigned a);
    longint unsigned r;
    longint unsigned t2;
    longint unsigned t3;
    longint unsigned t4;
    longint unsigned e;
    longint unsigned den;
    longint unsigned q;
    r  = a << 7;
    t2 = ((r * r) >> 31) / 2;
    t3 = ((t2 * r) >> 31) / 3;
    t4 = ((t3 * r) >> 31) / 4;
    e  = (64'd1 << 31) - r + t2 - t3 + t4;
    // Square eight times to get e^-a from e^(-a/256)
    for (int k = 0; k < 8; k++) begin
      e = (e * e + (64'd1 << 30)) >> 31;
    end
    den = (64'd1 << 31) + e;
    q   = udiv((64'd1 << 47) + (den >> 1), den);
    return q[P_W-1:0];
  endfunction

  // Table entry: sigmoid at the left edge of bin idx over z in [-8,8)
  function automatic logic [P_W-1:0] sig_entry(input longint unsigned idx,
                                               input longint unsigned depth);
    longint unsigned q;
    longint          zq;
    logic [P_W-1:0]  s;
    q  = udiv(idx << Z_FRAC, depth);
    zq = longint'(q) - longint'(Z_HALF);
    if (zq >= 0) begin
      s = sig_pos(longint'(zq));
    end else begin
      s = P_W'(P_ONE) - sig_pos(longint'(-zq));
    end
    return s;
  endfunction

endpackage

>>> rtl/logistic_sgd_update.sv
// Top level of the online logistic regression trainer (two features and a bias).
// Depends on lsu_pkg, lsu_mul and lsu_sig_rom.
//
// Each accepted sample (feature_one, feature_two, target) runs through a
// twelve-step sequencer that drives one shared 33x33 signed multiplier: the two
// weight products for z, the table index scaling, p*(1-p), the error term, the
// learning rate scaling and the two weight increments, one product at a time
// with the sigmoid ROM read in between. The next item is taken once the
// sequencer is back in idle, so a sample is not accepted while the previous one
// is still in the sequence. The result sits in an output register; a new item
// is accepted while it waits, and the sequencer holds in its last step only if
// the previous result is still untaken. The sigmoid ROM is filled at
// elaboration, so the block is ready right after reset. The learning rate
// register is written through its own port, which is always ready.
module logistic_sgd_update #(
  parameter int unsigned SIGMOID_TABLE_DEPTH = lsu_pkg::DEF_SIGMOID_TABLE_DEPTH,
  parameter int unsigned FEATURE_WIDTH       = lsu_pkg::DEF_FEATURE_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Learning rate write
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lsu_pkg::RATE_W-1:0]        cfg_data_i,
  // Sample in
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [FEATURE_WIDTH-1:0]   feature_one_i,
  input  logic signed [FEATURE_WIDTH-1:0]   feature_two_i,
  input  logic [lsu_pkg::P_W-1:0]           target_i,
  // Result out
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [lsu_pkg::P_W-1:0]           prediction_o,
  output logic signed [lsu_pkg::W_W-1:0]    weight_one_o,
  output logic signed [lsu_pkg::W_W-1:0]    weight_two_o,
  output logic signed [lsu_pkg::W_W-1:0]    bias_out_o
);

  localparam int unsigned AddrW  = $clog2(SIGMOID_TABLE_DEPTH);
  localparam int unsigned ZW     = FEATURE_WIDTH + 26;
  localparam int unsigned MulW   = lsu_pkg::MUL_W;
  localparam int unsigned ProdW  = 2 * MulW;
  localparam int unsigned StepW  = lsu_pkg::STEP_W;
  localparam int unsigned DeltaW = lsu_pkg::DELTA_W;
  localparam int unsigned PW     = lsu_pkg::P_W;
  localparam int unsigned WW     = lsu_pkg::W_W;
  localparam int unsigned ZFrac  = lsu_pkg::Z_FRAC;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_SUMZ,
    S_MULI,
    S_ADDR,
    S_PMUL,
    S_GMUL,
    S_SMUL,
    S_STEP,
    S_D1,
    S_D2,
    S_FIN
  } state_e;

  state_e                          state_q;
  logic [lsu_pkg::RATE_W-1:0]      rate_q;
  logic signed [FEATURE_WIDTH-1:0] x1_q;
  logic signed [FEATURE_WIDTH-1:0] x2_q;
  logic [PW-1:0]                   t_q;
  logic signed [WW-1:0]            w1_q;
  logic signed [WW-1:0]            w2_q;
  logic signed [WW-1:0]            b_q;
  logic signed [ZW-1:0]            acc_q;
  logic                            sat_lo_q;
  logic                            sat_hi_q;
  logic [PW-1:0]                   p_q;
  logic signed [StepW-1:0]         step_q;
  logic                            out_valid_q;
  logic [PW-1:0]                   pred_q;
  logic signed [WW-1:0]            ow1_q;
  logic signed [WW-1:0]            ow2_q;
  logic signed [WW-1:0]            ob_q;

  logic                            mul_en;
  logic signed [MulW-1:0]          mul_a;
  logic signed [MulW-1:0]          mul_b;
  logic signed [ProdW-1:0]         prod;
  logic [AddrW-1:0]                rom_addr;
  logic [PW-1:0]                   rom_data;

  logic [ProdW-1:0]                rnd8;
  logic [ProdW-1:0]                rnd16;
  logic [ProdW-1:0]                rnd24;
  logic [ProdW-1:0]                rnd32;
  logic signed [ZW-1:0]            term8;
  logic signed [ZW-1:0]            zi;
  logic                            zi_lo;
  logic                            zi_hi;
  logic signed [DeltaW-1:0]        delta;
  logic [StepW:0]                  bias_sum;
  logic signed [DeltaW-1:0]        bias_delta;
  logic [PW-1:0]                   t_clamped;
  logic signed [StepW-1:0]         step_d;
  logic signed [WW-1:0]            w1_d;
  logic signed [WW-1:0]            w2_d;
  logic signed [WW-1:0]            b_d;
  logic                            fin_load;

  // Add an increment to a Q16.16 weight, clamp at the signed 32-bit limits
  function automatic logic signed [WW-1:0] sat_add(input logic signed [WW-1:0] w,
                                                   input logic signed [DeltaW-1:0] d);
    logic signed [DeltaW:0] s;
    logic signed [WW-1:0]   r;
    s = (DeltaW+1)'(w) + (DeltaW+1)'(d);
    if ((&s[DeltaW:WW-1]) || !(|s[DeltaW:WW-1])) begin
      r = s[WW-1:0];
    end else if (s[DeltaW]) begin
      r = {1'b1, {(WW-1){1'b0}}};
    end else begin
      r = {1'b0, {(WW-1){1'b1}}};
    end
    return r;
  endfunction

  lsu_mul #(
    .MulW (MulW)
  ) u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  lsu_sig_rom #(
    .Depth (SIGMOID_TABLE_DEPTH)
  ) u_rom (
    .clk_i  (clk_i),
    .addr_i (rom_addr),
    .data_o (rom_data)
  );

  // Round the registered product at the shifts the sequence needs
  assign rnd8  = prod + ProdW'(64'h80);
  assign rnd16 = prod + ProdW'(64'h8000);
  assign rnd24 = prod + ProdW'(64'h80_0000);
  assign rnd32 = prod + ProdW'(64'h8000_0000);

  assign term8 = $signed(rnd8[ZW+7:8]);
  assign delta = $signed(rnd24[DeltaW+23:24]);
  assign step_d = $signed(rnd32[StepW+31:32]);

  // Bias increment is the scaled gradient rounded to Q16.16
  assign bias_sum   = {step_q[StepW-1], step_q} + (StepW+1)'(32'h8000);
  assign bias_delta = DeltaW'($signed(bias_sum[StepW:16]));

  // Shift z onto the table span and flag the saturated ends
  assign zi    = acc_q + ZW'(lsu_pkg::Z_HALF);
  assign zi_lo = zi[ZW-1];
  assign zi_hi = !zi[ZW-1] && (|zi[ZW-2:ZFrac]);

  // Clamp target at 1.0
  assign t_clamped = (target_i > PW'(lsu_pkg::P_ONE)) ? PW'(lsu_pkg::P_ONE) : target_i;

  assign w1_d = sat_add(w1_q, delta);
  assign w2_d = sat_add(w2_q, delta);
  assign b_d  = sat_add(b_q, bias_delta);

  assign fin_load = (state_q == S_FIN) && (!out_valid_q || out_ready_i);

  // Pick the multiplier operands for the current step
  always_comb begin
    mul_en   = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    rom_addr = '0;
    unique case (state_q)
      S_MUL1: begin
        mul_en = 1'b1;
        mul_a  = MulW'(w1_q);
        mul_b  = MulW'(x1_q);
      end
      S_MUL2: begin
        mul_en = 1'b1;
        mul_a  = MulW'(w2_q);
        mul_b  = MulW'(x2_q);
      end
      S_MULI: begin
        mul_en = 1'b1;
        mul_a  = MulW'(zi[ZFrac-1:0]);
        mul_b  = MulW'(SIGMOID_TABLE_DEPTH);
      end
      S_ADDR: begin
        priority if (sat_lo_q) begin
          rom_addr = '0;
        end else if (sat_hi_q) begin
          rom_addr = AddrW'(SIGMOID_TABLE_DEPTH - 1);
        end else begin
          rom_addr = prod[ZFrac+AddrW-1:ZFrac];
        end
      end
      S_PMUL: begin
        mul_en = 1'b1;
        mul_a  = MulW'(rom_data);
        mul_b  = MulW'(lsu_pkg::P_ONE) - MulW'(rom_data);
      end
      S_GMUL: begin
        mul_en = 1'b1;
        mul_a  = MulW'(t_q) - MulW'(p_q);
        mul_b  = prod[MulW-1:0];
      end
      S_SMUL: begin
        mul_en = 1'b1;
        mul_a  = $signed(rnd16[MulW+15:16]);
        mul_b  = MulW'(rate_q);
      end
      S_D1: begin
        mul_en = 1'b1;
        mul_a  = MulW'(step_q);
        mul_b  = MulW'(x1_q);
      end
      S_D2: begin
        mul_en = 1'b1;
        mul_a  = MulW'(step_q);
        mul_b  = MulW'(x2_q);
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // Sequencer, model state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rate_q      <= lsu_pkg::RATE_RESET;
      w1_q        <= '0;
      w2_q        <= '0;
      b_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Take a learning rate write
      if (cfg_valid_i) begin
        rate_q <= cfg_data_i;
      end
      // Drop the result once taken
      if (out_valid_q && out_ready_i && !fin_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            x1_q    <= feature_one_i;
            x2_q    <= feature_two_i;
            t_q     <= t_clamped;
            state_q <= S_MUL1;
          end
        end
        S_MUL1: state_q <= S_MUL2;
        S_MUL2: begin
          acc_q   <= ZW'(b_q) + term8;
          state_q <= S_SUMZ;
        end
        S_SUMZ: begin
          acc_q   <= acc_q + term8;
          state_q <= S_MULI;
        end
        S_MULI: begin
          sat_lo_q <= zi_lo;
          sat_hi_q <= zi_hi;
          state_q  <= S_ADDR;
        end
        S_ADDR: state_q <= S_PMUL;
        S_PMUL: begin
          p_q     <= rom_data;
          state_q <= S_GMUL;
        end
        S_GMUL: state_q <= S_SMUL;
        S_SMUL: state_q <= S_STEP;
        S_STEP: begin
          step_q  <= step_d;
          state_q <= S_D1;
        end
        S_D1: state_q <= S_D2;
        S_D2: begin
          w1_q    <= w1_d;
          state_q <= S_FIN;
        end
        S_FIN: begin
          // Hold here while the previous result is untaken
          if (fin_load) begin
            w2_q        <= w2_d;
            b_q         <= b_d;
            pred_q      <= p_q;
            ow1_q       <= w1_q;
            ow2_q       <= w2_d;
            ob_q        <= b_d;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign cfg_ready_o  = 1'b1;
  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign prediction_o = pred_q;
  assign weight_one_o = ow1_q;
  assign weight_two_o = ow2_q;
  assign bias_out_o   = ob_q;

endmodule

>>> rtl/lsu_sig_rom.sv
// Sigmoid lookup ROM with registered read.
// Contents are built at elaboration from lsu_pkg::sig_entry.
// Depends on lsu_pkg.
module lsu_sig_rom #(
  parameter int unsigned Depth = lsu_pkg::DEF_SIGMOID_TABLE_DEPTH
) (
  input  logic                       clk_i,
  input  logic [$clog2(Depth)-1:0]   addr_i,
  output logic [lsu_pkg::P_W-1:0]    data_o
);

  typedef logic [lsu_pkg::P_W-1:0] rom_t [Depth];

  function automatic rom_t build_rom();
    rom_t tab;
    for (int i = 0; i < Depth; i++) begin
      tab[i] = lsu_pkg::sig_entry(longint'(i), longint'(Depth));
    end
    return tab;
  endfunction

  localparam rom_t RomData = build_rom();

  logic [lsu_pkg::P_W-1:0] data_q;

  // Register the read data
  always_ff @(posedge clk_i) begin
    data_q <= RomData[addr_i];
  end

  assign data_o = data_q;

endmodule

>>> rtl/lsu_mul.sv
// Shared signed multiplier with a registered product.
// Every product of the update sequence goes through this unit.
// Depends on lsu_pkg.
module lsu_mul #(
  parameter int unsigned MulW = lsu_pkg::MUL_W
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic signed [MulW-1:0]     a_i,
  input  logic signed [MulW-1:0]     b_i,
  output logic signed [2*MulW-1:0]   prod_o
);

  logic signed [2*MulW-1:0] prod_q;

  // Load a new product when issued, hold otherwise
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  assign prod_o = prod_q;

endmodule

>>> bench/tb_logistic_sgd_update.sv
`timescale 1ns / 1ps
// Self-checking bench for logistic_sgd_update: trains the block on directed and random samples
// under several learning rates and checks every update against a local fixed-point model.
// Depends on lsu_pkg and the logistic_sgd_update RTL.
module tb_logistic_sgd_update;

  localparam int FW          = lsu_pkg::DEF_FEATURE_WIDTH;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 108;
  localparam int LONG_HOLD   = 300;

  // Local model of the trainer: weights, rate, sigmoid table and pending updates
  class weight_tracker;
    typedef struct {
      logic [lsu_pkg::P_W-1:0] prob;
      logic [lsu_pkg::W_W-1:0] w_one;
      logic [lsu_pkg::W_W-1:0] w_two;
      logic [lsu_pkg::W_W-1:0] bias;
    } update_t;

    logic [lsu_pkg::P_W-1:0] sigmoid_lut [lsu_pkg::DEF_SIGMOID_TABLE_DEPTH];
    longint  w_one;
    longint  w_two;
    longint  bias;
    longint  step_size;
    update_t pending_updates [$];
    int      errors;
    int      checked;
    int      seen;

    function new();
      longint depth;
      longint zq;
      int     i;
      w_one     = 0;
      w_two     = 0;
      bias      = 0;
      step_size = longint'(lsu_pkg::RATE_RESET);
      errors    = 0;
      checked   = 0;
      seen      = 0;
      depth     = lsu_pkg::DEF_SIGMOID_TABLE_DEPTH;
      // Each entry holds the sigmoid at the left edge of its bin over [-8,8)
      for (i = 0; i < depth; i++) begin
        zq = (longint'(i) << 20) / depth - (longint'(1) << 19);
        sigmoid_lut[i] = sigmoid_at(zq);
      end
    endfunction

    // Sigmoid of a Q16.16 argument: Taylor e^(-a/256), square eight times, divide
    function logic [lsu_pkg::P_W-1:0] sigmoid_at(longint zq);
      longint unsigned a;
      longint unsigned r;
      longint unsigned sq;
      longint unsigned cube;
      longint unsigned quart;
      longint unsigned e;
      longint unsigned den;
      longint unsigned s;
      logic [lsu_pkg::P_W-1:0] res;
      int k;
      a     = (zq < 0) ? -zq : zq;
      r     = a << 7;
      sq    = ((r * r) >> 31) / 2;
      cube  = ((sq * r) >> 31) / 3;
      quart = ((cube * r) >> 31) / 4;
      e     = (64'd1 << 31) - r + sq - cube + quart;
      for (k = 0; k < 8; k++) begin
        e = (e * e + (64'd1 << 30)) >> 31;
      end
      den = (64'd1 << 31) + e;
      s   = ((64'd1 << 47) + den / 2) / den;
      if (zq < 0) s = 64'd65536 - s;
      res = s[lsu_pkg::P_W-1:0];
      return res;
    endfunction

    // Round to nearest, ties toward +inf
    function longint round_shift(longint v, int sh);
      return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function longint clamp_q16(longint v);
      if (v > (longint'(1) <<< 31) - 1) return (longint'(1) <<< 31) - 1;
      if (v < -(longint'(1) <<< 31)) return -(longint'(1) <<< 31);
      return v;
    endfunction

    // Run one training step on an accepted sample and queue the update it causes
    function void predict_update(logic signed [lsu_pkg::DEF_FEATURE_WIDTH-1:0] x1,
                                 logic signed [lsu_pkg::DEF_FEATURE_WIDTH-1:0] x2,
                                 logic [lsu_pkg::P_W-1:0] tgt);
      longint  f1;
      longint  f2;
      longint  t;
      longint  z;
      longint  zi;
      longint  idx;
      longint  depth;
      longint  p;
      longint  g;
      longint  step;
      update_t u;
      f1    = longint'(x1);
      f2    = longint'(x2);
      t     = longint'(tgt);
      depth = lsu_pkg::DEF_SIGMOID_TABLE_DEPTH;
      if (t > 65536) t = 65536;
      z  = bias + round_shift(w_one * f1, 8) + round_shift(w_two * f2, 8);
      // Saturate the table index outside [-8,8)
      zi = z + (longint'(1) <<< 19);
      if (zi < 0) idx = 0;
      else if (zi >= (longint'(1) <<< 20)) idx = depth - 1;
      else idx = (zi * depth) >>> 20;
      if (idx > depth - 1) idx = depth - 1;
      p    = longint'(sigmoid_lut[int'(idx)]);
      g    = round_shift((t - p) * p * (65536 - p), 16);
      step = round_shift(g * step_size, 32);
      w_one = clamp_q16(w_one + round_shift(step * f1, 24));
      w_two = clamp_q16(w_two + round_shift(step * f2, 24));
      bias  = clamp_q16(bias + round_shift(step, 16));
      u.prob  = p[lsu_pkg::P_W-1:0];
      u.w_one = w_one[31:0];
      u.w_two = w_two[31:0];
      u.bias  = bias[31:0];
      pending_updates.push_back(u);
      seen++;
    endfunction

    task report(string what, longint got, longint want);
      errors++;
      $display("mismatch at update %0d: %s is 0x%0h, expected 0x%0h",
               checked, what, got, want);
    endtask

    // Compare a delivered update with the oldest pending one
    task check_update(logic [lsu_pkg::P_W-1:0] prob, logic [lsu_pkg::W_W-1:0] w1,
                      logic [lsu_pkg::W_W-1:0] w2, logic [lsu_pkg::W_W-1:0] b);
      update_t u;
      if (pending_updates.size() == 0) begin
        report("update with no sample pending, prediction", longint'(prob), longint'(0));
        return;
      end
      u = pending_updates.pop_front();
      if (prob !== u.prob) report("prediction", longint'(prob), longint'(u.prob));
      if (w1 !== u.w_one) report("weight_one", longint'(w1), longint'(u.w_one));
      if (w2 !== u.w_two) report("weight_two", longint'(w2), longint'(u.w_two));
      if (b !== u.bias) report("bias_out", longint'(b), longint'(u.bias));
      checked++;
    endtask
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [lsu_pkg::RATE_W-1:0]    cfg_data_i;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic signed [FW-1:0]          feature_one_i;
  logic signed [FW-1:0]          feature_two_i;
  logic [lsu_pkg::P_W-1:0]       target_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic [lsu_pkg::P_W-1:0]       prediction_o;
  logic signed [lsu_pkg::W_W-1:0] weight_one_o;
  logic signed [lsu_pkg::W_W-1:0] weight_two_o;
  logic signed [lsu_pkg::W_W-1:0] bias_out_o;

  weight_tracker tracker;
  bit            calm;
  bit            long_hold_req;
  int            rate_writes;

  logistic_sgd_update DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .feature_one_i (feature_one_i),
    .feature_two_i (feature_two_i),
    .target_i      (target_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .prediction_o  (prediction_o),
    .weight_one_o  (weight_one_o),
    .weight_two_o  (weight_two_o),
    .bias_out_o    (bias_out_o)
  );

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watch both handshakes: train the model on accepted samples, check delivered updates
  always @(posedge clk_i) begin : observe
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        tracker.predict_update(feature_one_i, feature_two_i, target_i);
      end
      if (out_valid_o && out_ready_i) begin
        tracker.check_update(prediction_o, weight_one_o, weight_two_o, bias_out_o);
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off on request, none once calm
  initial begin : result_sink
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("tb: failure");
    $finish;
  end

  // Offer one sample, after an optional idle burst, and hold it until accepted
  task automatic send_sample(input logic signed [FW-1:0] x1, input logic signed [FW-1:0] x2,
                             input logic [lsu_pkg::P_W-1:0] tgt);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    feature_one_i <= x1;
    feature_two_i <= x2;
    target_i      <= tgt;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Drop valid and hold until every pending update has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tracker.pending_updates.size() != 0);
  endtask

  task automatic set_rate(input logic [lsu_pkg::RATE_W-1:0] r);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= r;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    tracker.step_size = longint'(r);
    rate_writes++;
  endtask

  function automatic logic signed [FW-1:0] pick_feature();
    logic signed [FW-1:0] v;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      case ($urandom_range(0, 4))
        0: v = {1'b0, {(FW-1){1'b1}}};
        1: v = {1'b1, {(FW-1){1'b0}}};
        2: v = '0;
        3: v = '1;
        default: v = FW'(1);
      endcase
    end else if (sel < 3) begin
      v = FW'(int'($urandom_range(0, 1024)) - 512);
    end else begin
      v = FW'($urandom);
    end
    return v;
  endfunction

  // Random sample; with follow_rule most targets come from a separable rule
  task automatic send_random(input bit follow_rule);
    logic signed [FW-1:0]    x1;
    logic signed [FW-1:0]    x2;
    logic [lsu_pkg::P_W-1:0] t;
    int                      sel;
    x1  = pick_feature();
    x2  = pick_feature();
    sel = $urandom_range(0, 19);
    if (follow_rule && sel < 12) t = (longint'(x1) + longint'(x2) > 0) ? 17'd65536 : 17'd0;
    else if (sel < 15) t = $urandom_range(0, 1) ? 17'd65536 : 17'd0;
    else if (sel < 18) t = 17'($urandom_range(0, lsu_pkg::P_ONE));
    else t = 17'($urandom_range(lsu_pkg::P_ONE + 1, (1 << lsu_pkg::P_W) - 1));
    send_sample(x1, x2, t);
  endtask

  initial begin : stimulus
    logic [lsu_pkg::RATE_W-1:0] rate_plan [6];
    int phase;
    int n;
    tracker       = new();
    calm          = 1'b0;
    long_hold_req = 1'b0;
    rate_writes   = 0;
    rst_ni        <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    in_valid_i    <= 1'b0;
    feature_one_i <= '0;
    feature_two_i <= '0;
    target_i      <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Train a few samples at the reset learning rate
    send_sample(16'sh7FFF, 16'sh7FFF, 17'd65536);
    send_sample(16'sh8000, 16'sh0100, 17'd0);
    send_sample(16'sh0000, 16'sh0000, 17'd131071);
    wait_drained();

    // Full-scale rate: push z past +8, then far below -8, targets above 1.0
    set_rate('1);
    send_sample(16'sh0000, 16'sh0000, 17'd0);
    send_sample(16'sh0000, 16'sh0000, 17'd65536);
    repeat (5) send_sample(16'sh7FFF, 16'sh0000, 17'd65536);
    send_sample(16'sh7FFF, 16'sh7FFF, 17'd65536);
    send_sample(16'sh8000, 16'sh8000, 17'd131071);
    send_sample(16'sh8000, 16'sh0000, 17'd65537);
    send_sample(16'sh0000, 16'sh8000, 17'd0);
    repeat (3) send_sample(16'sh0000, 16'sh7FFF, 17'd0);
    send_sample(16'shFFFF, 16'sh0001, 17'd32768);
    send_sample(16'sh0100, 16'shFF00, 17'd65535);
    send_sample(16'sh7FFF, 16'sh8000, 17'd1);
    send_sample(16'sh8000, 16'sh7FFF, 17'd131071);
    wait_drained();

    // Zero rate leaves the weights frozen
    set_rate('0);
    send_sample(16'sh7FFF, 16'sh7FFF, 17'd0);
    send_sample(16'sh8000, 16'sh8000, 17'd65536);

    rate_plan[0] = '1;
    rate_plan[1] = '0;
    rate_plan[2] = lsu_pkg::RATE_RESET;
    rate_plan[3] = 24'($urandom_range(0, (1 << lsu_pkg::RATE_W) - 1));
    rate_plan[4] = 24'($urandom_range(0, 1000));
    rate_plan[5] = '1;

    // Random phases, each at its own rate, drained before the next write
    for (phase = 0; phase < 6; phase++) begin
      wait_drained();
      set_rate(rate_plan[phase]);
      if (phase == 2) long_hold_req = 1'b1;
      if (phase == 5) calm = 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        send_random(phase == 0 || phase == 3 || phase == 5);
      end
    end
    wait_drained();
    repeat (20) @(posedge clk_i);

    $display("summary: %0d samples trained, %0d updates checked, %0d rate writes",
             tracker.seen, tracker.checked, rate_writes);
    $display("summary: rates zero, full scale, reset value and random; z saturated both ways");
    if (tracker.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
